### design/lbd_pkg.sv
// Shared types, codes and constants for the D1Q3 lattice Boltzmann diffusion block.
package lbd_pkg;

    // Default sizing of the lattice store
    localparam int MAX_CELLS_DEF  = 128;
    localparam int VALUE_BITS_DEF = 24;

    // Fixed field widths on the channels
    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 7;
    localparam int IO_VALUE_W = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 18;

    // Configuration register widths, limits and reset values
    localparam int RELAX_W = 18;
    localparam int MOVE_W  = 17;
    localparam int CELLS_W = 8;
    localparam int FRAC_W  = 18;

    localparam logic [RELAX_W-1:0] RELAX_MAX   = 18'd131072;
    localparam logic [MOVE_W-1:0]  ONE_Q16     = 17'd65536;
    localparam logic [RELAX_W-1:0] RELAX_RESET = 18'd65536;
    localparam logic [MOVE_W-1:0]  MOVE_RESET  = 17'd19661;
    localparam logic [CELLS_W-1:0] CELLS_RESET = 8'd100;

    // Item kinds; the unused code behaves as a read
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_STEP = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RELAX = 2'd0,
        CFG_MOVE  = 2'd1,
        CFG_CELLS = 2'd2
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_LOAD_MR,
        ST_LOAD_MM,
        ST_LOAD_WM,
        ST_C_READ,
        ST_C_SUM,
        ST_C_EQR,
        ST_C_EQM,
        ST_C_DIFF,
        ST_C_MREST,
        ST_C_MRIGHT,
        ST_C_MLEFT,
        ST_C_WLEFT,
        ST_FIN,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT
    } state_t;

endpackage

### design/lbd_if.sv
// Channel interfaces: command, response and configuration write.
interface lbd_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [lbd_pkg::KIND_W-1:0]            kind;
    logic [lbd_pkg::INDEX_W-1:0]           cell_index;
    logic signed [lbd_pkg::IO_VALUE_W-1:0] density_in;

    modport source (output valid, kind, cell_index, density_in, input ready);
    modport sink   (input valid, kind, cell_index, density_in, output ready);
endinterface

interface lbd_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lbd_pkg::IO_VALUE_W-1:0] density_out;
    logic                                  saturated;

    modport source (output valid, density_out, saturated, input ready);
    modport sink   (input valid, density_out, saturated, output ready);
endinterface

interface lbd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lbd_pkg::CFG_ADDR_W-1:0]    addr;
    logic [lbd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### design/lattice_boltzmann_d1q3_diffusion.sv
// Top level: D1Q3 lattice Boltzmann diffusion ring with one shared multiplier.
// A command passes a reduce state that folds cell_index down by MAX_CELLS until
// it lies in the store; a load writes the density and scaled populations, a step
// runs the collision sequence over every ring cell, and each kind ends with a
// registered density read and a capture state. One command at a time, as cmd.ready
// is high only in idle: the per-cell collision sequence through the single
// multiplier sets the step time. rst_n resets the sequencer and the configuration
// registers; lattice memories hold no reset value and must be loaded before use.
module lattice_boltzmann_d1q3_diffusion #(
    parameter int MAX_CELLS  = lbd_pkg::MAX_CELLS_DEF,
    parameter int VALUE_BITS = lbd_pkg::VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lbd_cmd_if.sink    cmd,
    lbd_rsp_if.source  rsp,
    lbd_cfg_if.sink    cfg
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int MW = VALUE_BITS + 1;
    localparam int PW = MW + lbd_pkg::FRAC_W;
    localparam int CW = (VALUE_BITS + 4 > 26) ? VALUE_BITS + 4 : 26;
    localparam int IW = lbd_pkg::INDEX_W;
    localparam int OW = lbd_pkg::IO_VALUE_W;

    localparam logic signed [CW-1:0] V_MAX =
        {{(CW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [CW-1:0] V_MIN = ~V_MAX;
    localparam logic signed [CW-1:0] O_MAX = {{(CW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [CW-1:0] O_MIN = ~O_MAX;

    // Saturate a wide value to the stored width
    function automatic logic signed [VALUE_BITS-1:0] clip_v(input logic signed [CW-1:0] v);
        logic signed [VALUE_BITS-1:0] r;
        if (v > V_MAX)
            r = V_MAX[VALUE_BITS-1:0];
        else if (v < V_MIN)
            r = V_MIN[VALUE_BITS-1:0];
        else
            r = v[VALUE_BITS-1:0];
        return r;
    endfunction

    function automatic logic ovf_v(input logic signed [CW-1:0] v);
        return (v > V_MAX) || (v < V_MIN);
    endfunction

    // Round magnitude product by 2^16 or 2^17, ties away from zero, restore sign
    function automatic logic signed [CW-1:0] rnd_q(input logic [PW-1:0] mag,
                                                   input logic neg,
                                                   input logic half17);
        logic [PW:0] s;
        logic [PW:0] r;
        s = {1'b0, mag} + (half17 ? (PW+1)'(1 << 16) : (PW+1)'(1 << 15));
        r = half17 ? (s >> 17) : (s >> 16);
        return neg ? -CW'(r) : CW'(r);
    endfunction

    // Configuration registers
    logic [lbd_pkg::RELAX_W-1:0] relax_reg;
    logic [lbd_pkg::MOVE_W-1:0]  move_reg;
    logic [lbd_pkg::CELLS_W-1:0] cells_reg;

    lbd_pkg::state_t state_reg, state_next;

    // Datapath registers
    lbd_pkg::kind_t               kind_reg;
    logic [IW-1:0]                idx_reg;
    logic [AW-1:0]                ci_reg;
    logic signed [VALUE_BITS-1:0] rho_reg;
    logic signed [VALUE_BITS-1:0] eqr_reg;
    logic signed [VALUE_BITS-1:0] eqm_reg;
    logic signed [MW-1:0]         diff_reg;
    logic signed [VALUE_BITS-1:0] carry_reg;
    logic signed [VALUE_BITS-1:0] keep_reg;
    logic                         sat_reg;
    logic signed [OW-1:0]         out_reg;
    logic [PW-1:0]                prod_reg;
    logic                         neg_reg;

    // Memory read data
    logic signed [VALUE_BITS-1:0] rest_rd_reg, right_rd_reg, left_rd_reg, dens_rd_reg;

    // Lattice memories
    logic signed [VALUE_BITS-1:0] rest_mem  [MAX_CELLS];
    logic signed [VALUE_BITS-1:0] right_mem [MAX_CELLS];
    logic signed [VALUE_BITS-1:0] left_mem  [MAX_CELLS];
    logic signed [VALUE_BITS-1:0] dens_mem  [MAX_CELLS];

    // Effective settings
    logic [lbd_pkg::RELAX_W-1:0] eff_w;
    logic [lbd_pkg::MOVE_W-1:0]  eff_t;
    logic [lbd_pkg::MOVE_W-1:0]  omt;
    logic [AW-1:0]               last_c;
    logic [AW-1:0]               idx_addr;
    logic                        idx_fold;

    // Combinational datapath
    logic                         cmd_beat;
    logic signed [CW-1:0]         load_ext;
    logic signed [CW-1:0]         sum_ext;
    logic signed [VALUE_BITS-1:0] sum_clip;
    logic                         sum_ovf;
    logic signed [CW-1:0]         rnd_val;
    logic signed [VALUE_BITS-1:0] rnd_clip;
    logic                         rnd_ovf;
    logic signed [VALUE_BITS-1:0] f_sel;
    logic signed [CW-1:0]         upd_ext;
    logic signed [VALUE_BITS-1:0] upd_clip;
    logic                         upd_ovf;
    logic signed [CW-1:0]         out_ext;
    logic                         out_ovf;
    logic                         half17;

    // Shared multiplier controls
    logic                        mul_en;
    logic signed [MW-1:0]        mul_a;
    logic [lbd_pkg::FRAC_W-1:0]  mul_b;
    logic [MW-1:0]               mul_mag;

    // Memory port controls
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         we_rest, we_right, we_left, we_dens;
    logic [AW-1:0]                wa_rest, wa_right, wa_left, wa_dens;
    logic signed [VALUE_BITS-1:0] wd_rest, wd_right, wd_left, wd_dens;

    assign cmd_beat = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == lbd_pkg::ST_IDLE);
    assign rsp.valid = (state_reg == lbd_pkg::ST_OUT);
    assign rsp.density_out = out_reg;
    assign rsp.saturated = sat_reg;
    assign cfg.ready = 1'b1;

    // Clamp settings to their legal ranges
    always_comb
    begin
        eff_w = (relax_reg > lbd_pkg::RELAX_MAX) ? lbd_pkg::RELAX_MAX : relax_reg;
        eff_t = (move_reg > lbd_pkg::ONE_Q16) ? lbd_pkg::ONE_Q16 : move_reg;
        omt   = lbd_pkg::ONE_Q16 - eff_t;
        if (cells_reg == '0)
            last_c = '0;
        else if (32'(cells_reg) > MAX_CELLS)
            last_c = AW'(MAX_CELLS - 1);
        else
            last_c = AW'(cells_reg - 8'd1);
        idx_fold = (32'(idx_reg) >= MAX_CELLS);
        idx_addr = AW'(idx_reg);
    end

    // Saturating arithmetic around the multiplier
    always_comb
    begin
        load_ext = CW'(cmd.density_in);
        sum_ext  = CW'(rest_rd_reg) + CW'(right_rd_reg) + CW'(left_rd_reg);
        sum_clip = clip_v(sum_ext);
        sum_ovf  = ovf_v(sum_ext);
        half17   = (state_reg == lbd_pkg::ST_C_DIFF) || (state_reg == lbd_pkg::ST_LOAD_WM);
        rnd_val  = rnd_q(prod_reg, neg_reg, half17);
        rnd_clip = clip_v(rnd_val);
        rnd_ovf  = ovf_v(rnd_val);
        case (state_reg)
            lbd_pkg::ST_C_MRIGHT: f_sel = rest_rd_reg;
            lbd_pkg::ST_C_MLEFT:  f_sel = right_rd_reg;
            default:              f_sel = left_rd_reg;
        endcase
        upd_ext  = CW'(f_sel) + CW'(rnd_clip);
        upd_clip = clip_v(upd_ext);
        upd_ovf  = ovf_v(upd_ext);
        out_ext  = CW'(dens_rd_reg);
        out_ovf  = (out_ext > O_MAX) || (out_ext < O_MIN);
        mul_mag  = mul_a[MW-1] ? MW'(-mul_a) : MW'(mul_a);
    end

    // Sequencer: next state, multiplier operands and memory ports
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = MW'(rho_reg);
        mul_b      = lbd_pkg::FRAC_W'(omt);
        rd_en      = 1'b0;
        rd_addr    = ci_reg;
        we_rest    = 1'b0;
        we_right   = 1'b0;
        we_left    = 1'b0;
        we_dens    = 1'b0;
        wa_rest    = ci_reg;
        wa_right   = ci_reg;
        wa_left    = ci_reg;
        wa_dens    = ci_reg;
        wd_rest    = rnd_clip;
        wd_right   = rnd_clip;
        wd_left    = rnd_clip;
        wd_dens    = rho_reg;
        case (state_reg)
            lbd_pkg::ST_IDLE:
            begin
                if (cmd_beat)
                    state_next = lbd_pkg::ST_REDUCE;
            end
            lbd_pkg::ST_REDUCE:
            begin
                if (!idx_fold)
                begin
                    case (kind_reg)
                        lbd_pkg::KIND_LOAD: state_next = lbd_pkg::ST_LOAD_MR;
                        lbd_pkg::KIND_STEP: state_next = lbd_pkg::ST_C_READ;
                        default:            state_next = lbd_pkg::ST_OUT_RD;
                    endcase
                end
            end
            lbd_pkg::ST_LOAD_MR:
            begin
                mul_en     = 1'b1;
                we_dens    = 1'b1;
                wa_dens    = idx_addr;
                state_next = lbd_pkg::ST_LOAD_MM;
            end
            lbd_pkg::ST_LOAD_MM:
            begin
                mul_en     = 1'b1;
                mul_b      = lbd_pkg::FRAC_W'(eff_t);
                we_rest    = 1'b1;
                wa_rest    = idx_addr;
                state_next = lbd_pkg::ST_LOAD_WM;
            end
            lbd_pkg::ST_LOAD_WM:
            begin
                we_right   = 1'b1;
                wa_right   = idx_addr;
                we_left    = 1'b1;
                wa_left    = idx_addr;
                state_next = lbd_pkg::ST_OUT_RD;
            end
            lbd_pkg::ST_C_READ:
            begin
                rd_en      = 1'b1;
                state_next = lbd_pkg::ST_C_SUM;
            end
            lbd_pkg::ST_C_SUM:
            begin
                // Density of this cell, and the right mover streamed in from below
                we_dens    = 1'b1;
                wd_dens    = sum_clip;
                we_right   = (ci_reg != '0);
                wd_right   = carry_reg;
                state_next = lbd_pkg::ST_C_EQR;
            end
            lbd_pkg::ST_C_EQR:
            begin
                mul_en     = 1'b1;
                state_next = lbd_pkg::ST_C_EQM;
            end
            lbd_pkg::ST_C_EQM:
            begin
                mul_en     = 1'b1;
                mul_b      = lbd_pkg::FRAC_W'(eff_t);
                state_next = lbd_pkg::ST_C_DIFF;
            end
            lbd_pkg::ST_C_DIFF:
            begin
                state_next = lbd_pkg::ST_C_MREST;
            end
            lbd_pkg::ST_C_MREST:
            begin
                mul_en     = 1'b1;
                mul_a      = diff_reg;
                mul_b      = eff_w;
                state_next = lbd_pkg::ST_C_MRIGHT;
            end
            lbd_pkg::ST_C_MRIGHT:
            begin
                mul_en     = 1'b1;
                mul_a      = diff_reg;
                mul_b      = eff_w;
                we_rest    = 1'b1;
                wd_rest    = upd_clip;
                state_next = lbd_pkg::ST_C_MLEFT;
            end
            lbd_pkg::ST_C_MLEFT:
            begin
                mul_en     = 1'b1;
                mul_a      = diff_reg;
                mul_b      = eff_w;
                state_next = lbd_pkg::ST_C_WLEFT;
            end
            lbd_pkg::ST_C_WLEFT:
            begin
                // Stream the left mover down one cell
                we_left    = (ci_reg != '0);
                wa_left    = ci_reg - AW'(1);
                wd_left    = upd_clip;
                state_next = (ci_reg == last_c) ? lbd_pkg::ST_FIN : lbd_pkg::ST_C_READ;
            end
            lbd_pkg::ST_FIN:
            begin
                // Close the ring on both movers
                we_right   = 1'b1;
                wa_right   = '0;
                wd_right   = carry_reg;
                we_left    = 1'b1;
                wa_left    = last_c;
                wd_left    = keep_reg;
                state_next = lbd_pkg::ST_OUT_RD;
            end
            lbd_pkg::ST_OUT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_addr;
                state_next = lbd_pkg::ST_OUT_CAP;
            end
            lbd_pkg::ST_OUT_CAP:
            begin
                state_next = lbd_pkg::ST_OUT;
            end
            lbd_pkg::ST_OUT:
            begin
                if (rsp.ready)
                    state_next = lbd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lbd_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbd_pkg::ST_IDLE;
            relax_reg <= lbd_pkg::RELAX_RESET;
            move_reg  <= lbd_pkg::MOVE_RESET;
            cells_reg <= lbd_pkg::CELLS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (lbd_pkg::cfg_reg_t'(cfg.addr))
                    lbd_pkg::CFG_RELAX: relax_reg <= cfg.data;
                    lbd_pkg::CFG_MOVE:  move_reg  <= cfg.data[lbd_pkg::MOVE_W-1:0];
                    lbd_pkg::CFG_CELLS: cells_reg <= cfg.data[lbd_pkg::CELLS_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // Shared multiplier: magnitude product, sign kept aside
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PW'(mul_mag) * PW'(mul_b);
            neg_reg  <= mul_a[MW-1];
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lbd_pkg::ST_IDLE:
            begin
                if (cmd_beat)
                begin
                    kind_reg <= lbd_pkg::kind_t'(cmd.kind);
                    idx_reg  <= cmd.cell_index;
                    ci_reg   <= '0;
                    rho_reg  <= clip_v(load_ext);
                    sat_reg  <= (lbd_pkg::kind_t'(cmd.kind) == lbd_pkg::KIND_LOAD)
                                && ovf_v(load_ext);
                end
            end
            lbd_pkg::ST_REDUCE:
            begin
                if (idx_fold)
                    idx_reg <= idx_reg - IW'(MAX_CELLS);
            end
            lbd_pkg::ST_LOAD_MM, lbd_pkg::ST_LOAD_WM, lbd_pkg::ST_C_EQM:
            begin
                sat_reg <= sat_reg | rnd_ovf;
                if (state_reg == lbd_pkg::ST_C_EQM)
                    eqr_reg <= rnd_clip;
            end
            lbd_pkg::ST_C_SUM:
            begin
                rho_reg <= sum_clip;
                sat_reg <= sat_reg | sum_ovf;
            end
            lbd_pkg::ST_C_DIFF:
            begin
                eqm_reg  <= rnd_clip;
                sat_reg  <= sat_reg | rnd_ovf;
                diff_reg <= MW'(eqr_reg) - MW'(rest_rd_reg);
            end
            lbd_pkg::ST_C_MREST:
            begin
                diff_reg <= MW'(eqm_reg) - MW'(right_rd_reg);
            end
            lbd_pkg::ST_C_MRIGHT:
            begin
                diff_reg <= MW'(eqm_reg) - MW'(left_rd_reg);
                sat_reg  <= sat_reg | rnd_ovf | upd_ovf;
            end
            lbd_pkg::ST_C_MLEFT:
            begin
                carry_reg <= upd_clip;
                sat_reg   <= sat_reg | rnd_ovf | upd_ovf;
            end
            lbd_pkg::ST_C_WLEFT:
            begin
                sat_reg <= sat_reg | rnd_ovf | upd_ovf;
                if (ci_reg == '0)
                    keep_reg <= upd_clip;
                if (ci_reg != last_c)
                    ci_reg <= ci_reg + AW'(1);
            end
            lbd_pkg::ST_OUT_CAP:
            begin
                sat_reg <= sat_reg | out_ovf;
                if (out_ext > O_MAX)
                    out_reg <= O_MAX[OW-1:0];
                else if (out_ext < O_MIN)
                    out_reg <= O_MIN[OW-1:0];
                else
                    out_reg <= out_ext[OW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Lattice memories: one write per store, registered reads at a shared address
    always_ff @(posedge clk)
    begin
        if (we_rest)
            rest_mem[wa_rest] <= wd_rest;
        if (we_right)
            right_mem[wa_right] <= wd_right;
        if (we_left)
            left_mem[wa_left] <= wd_left;
        if (we_dens)
            dens_mem[wa_dens] <= wd_dens;
        if (rd_en)
        begin
            rest_rd_reg  <= rest_mem[rd_addr];
            right_rd_reg <= right_mem[rd_addr];
            left_rd_reg  <= left_mem[rd_addr];
            dens_rd_reg  <= dens_mem[rd_addr];
        end
    end

endmodule

### design/lbd_checker.sv
// Port-level checks on the diffusion block, bound to its top level.
module lbd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  cmd_valid,
    input logic                                  cmd_ready,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic signed [lbd_pkg::IO_VALUE_W-1:0] rsp_density_out,
    input logic                                  rsp_saturated
);

    // Hold a stalled response beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_density_out)
                                    && $stable(rsp_saturated))
        else $error("response beat changed while stalled");

    // Never take a command while a response is pending
    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ready && rsp_valid))
        else $error("command accepted with response pending");

    // Drop ready once a command beat is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("ready held after command beat");

    // Drop valid once a response beat is taken
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("second response beat without a command");

endmodule

bind lattice_boltzmann_d1q3_diffusion lbd_checker u_lbd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_density_out (rsp.density_out),
    .rsp_saturated   (rsp.saturated)
);

### tb/sv/testbench.sv
// Self-checking testbench for the D1Q3 lattice Boltzmann diffusion ring.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_COUNT = lbd_pkg::MAX_CELLS_DEF;
    localparam int VAL_W      = lbd_pkg::VALUE_BITS_DEF;

    localparam longint VAL_MAX = (longint'(1) << (VAL_W - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    // The spare codes have no name in the package
    localparam logic [lbd_pkg::KIND_W-1:0]     KIND_SPARE = 2'd3;
    localparam logic [lbd_pkg::CFG_ADDR_W-1:0] CFG_SPARE  = 2'd3;

    localparam logic [lbd_pkg::IO_VALUE_W-1:0] DENS_MAX  = 24'h7FFFFF;
    localparam logic [lbd_pkg::IO_VALUE_W-1:0] DENS_MIN  = 24'h800000;
    localparam logic [lbd_pkg::IO_VALUE_W-1:0] DENS_ZERO = 24'h000000;
    localparam logic [lbd_pkg::IO_VALUE_W-1:0] DENS_NEG1 = 24'hFFFFFF;
    localparam logic [lbd_pkg::IO_VALUE_W-1:0] DENS_LSB  = 24'h000001;

    localparam int SETTLE_CYCLES = 9 * CELL_COUNT + 40;

    typedef struct {
        int unsigned                           item_no;
        logic [lbd_pkg::KIND_W-1:0]            kind;
        logic [lbd_pkg::INDEX_W-1:0]           cell_no;
        logic signed [lbd_pkg::IO_VALUE_W-1:0] density;
        logic                                  saturated;
    } lattice_result_t;

    logic clk;
    logic rst_n;

    lbd_cmd_if cmd_ch();
    lbd_rsp_if rsp_ch();
    lbd_cfg_if cfg_ch();

    lattice_boltzmann_d1q3_diffusion DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Lattice mirror and register copies
    logic signed [VAL_W-1:0]      rest_pop    [CELL_COUNT];
    logic signed [VAL_W-1:0]      right_pop   [CELL_COUNT];
    logic signed [VAL_W-1:0]      left_pop    [CELL_COUNT];
    logic signed [VAL_W-1:0]      density_mem [CELL_COUNT];
    logic [lbd_pkg::RELAX_W-1:0]  relax_reg;
    logic [lbd_pkg::MOVE_W-1:0]   move_reg;
    logic [lbd_pkg::CELLS_W-1:0]  cells_reg;
    logic                         clip_hit;

    lattice_result_t expected_results [$];
    int unsigned     items_sent;
    int unsigned     mismatch_count;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin : watchdog
        #12_000_000;
        $display("lattice_boltzmann_d1q3_diffusion test failed");
        $finish;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Lattice predictor
    // ---------------------------------------------------------------

    function automatic longint clamp_value(input longint v);
        if (v > VAL_MAX)
        begin
            clip_hit = 1'b1;
            return VAL_MAX;
        end
        if (v < VAL_MIN)
        begin
            clip_hit = 1'b1;
            return VAL_MIN;
        end
        return v;
    endfunction

    // value * fraction / 2^shift, rounded to nearest, ties away from zero
    function automatic longint scale_round(input longint v, input longint frac, input int shift);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r   = (mag * frac + (longint'(1) << (shift - 1))) >>> shift;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint omega_now();
        longint w;
        w = longint'(relax_reg);
        return (w > longint'(lbd_pkg::RELAX_MAX)) ? longint'(lbd_pkg::RELAX_MAX) : w;
    endfunction

    function automatic longint frac_now();
        longint t;
        t = longint'(move_reg);
        return (t > longint'(lbd_pkg::ONE_Q16)) ? longint'(lbd_pkg::ONE_Q16) : t;
    endfunction

    function automatic int ring_len();
        if (cells_reg == 0)
            return 1;
        if (cells_reg > CELL_COUNT)
            return CELL_COUNT;
        return int'(cells_reg);
    endfunction

    function automatic void seed_cell(input int i,
                                      input logic signed [lbd_pkg::IO_VALUE_W-1:0] d);
        longint t;
        longint rho;
        t   = frac_now();
        rho = clamp_value(longint'(d));
        density_mem[i] = VAL_W'(rho);
        rest_pop[i]    = VAL_W'(clamp_value(
                             scale_round(rho, longint'(lbd_pkg::ONE_Q16) - t, 16)));
        right_pop[i]   = VAL_W'(clamp_value(scale_round(rho, t, 17)));
        left_pop[i]    = right_pop[i];
    endfunction

    // BGK relaxation of one cell towards its equilibrium
    function automatic void collide_cell(input int i);
        longint t;
        longint w;
        longint f_rest;
        longint f_right;
        longint f_left;
        longint rho;
        longint eq_rest;
        longint eq_move;
        t       = frac_now();
        w       = omega_now();
        f_rest  = longint'(rest_pop[i]);
        f_right = longint'(right_pop[i]);
        f_left  = longint'(left_pop[i]);
        rho     = clamp_value(f_rest + f_right + f_left);
        eq_rest = clamp_value(scale_round(rho, longint'(lbd_pkg::ONE_Q16) - t, 16));
        eq_move = clamp_value(scale_round(rho, t, 17));
        density_mem[i] = VAL_W'(rho);
        rest_pop[i]  = VAL_W'(clamp_value(
                           f_rest + clamp_value(scale_round(eq_rest - f_rest, w, 16))));
        right_pop[i] = VAL_W'(clamp_value(
                           f_right + clamp_value(scale_round(eq_move - f_right, w, 16))));
        left_pop[i]  = VAL_W'(clamp_value(
                           f_left + clamp_value(scale_round(eq_move - f_left, w, 16))));
    endfunction

    // Collide every cell in the ring, then rotate the movers one place
    function automatic void advance_ring();
        int n;
        logic signed [VAL_W-1:0] wrap;
        n = ring_len();
        for (int i = 0; i < n; i++)
            collide_cell(i);
        wrap = right_pop[n - 1];
        for (int i = n - 1; i > 0; i--)
            right_pop[i] = right_pop[i - 1];
        right_pop[0] = wrap;
        wrap = left_pop[0];
        for (int i = 0; i + 1 < n; i++)
            left_pop[i] = left_pop[i + 1];
        left_pop[n - 1] = wrap;
    endfunction

    function automatic void predict_lattice(input logic [lbd_pkg::KIND_W-1:0] kind,
                                            input logic [lbd_pkg::INDEX_W-1:0] cell_no,
                                            input logic signed [lbd_pkg::IO_VALUE_W-1:0] d);
        lattice_result_t res;
        clip_hit = 1'b0;
        case (kind)
            lbd_pkg::KIND_LOAD: seed_cell(int'(cell_no), d);
            lbd_pkg::KIND_STEP: advance_ring();
            default:            ;
        endcase
        res.item_no   = items_sent;
        res.kind      = kind;
        res.cell_no   = cell_no;
        res.density   = density_mem[cell_no];
        res.saturated = clip_hit;
        expected_results.push_back(res);
    endfunction

    function automatic void apply_register(input logic [lbd_pkg::CFG_ADDR_W-1:0] addr,
                                           input logic [lbd_pkg::CFG_DATA_W-1:0] data);
        case (addr)
            lbd_pkg::CFG_RELAX: relax_reg = data[lbd_pkg::RELAX_W-1:0];
            lbd_pkg::CFG_MOVE:  move_reg  = data[lbd_pkg::MOVE_W-1:0];
            lbd_pkg::CFG_CELLS: cells_reg = data[lbd_pkg::CELLS_W-1:0];
            default:            ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Channel drivers
    // ---------------------------------------------------------------

    // Send one command beat, idling at random first
    task automatic send_item(input logic [lbd_pkg::KIND_W-1:0] kind,
                             input logic [lbd_pkg::INDEX_W-1:0] cell_no,
                             input logic [lbd_pkg::IO_VALUE_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= kind;
        cmd_ch.cell_index <= cell_no;
        cmd_ch.density_in <= d;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        predict_lattice(kind, cell_no, d);
        items_sent++;
    endtask

    // Drop valid and hold until every response has come back
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_register(input logic [lbd_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [lbd_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        apply_register(addr, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [lbd_pkg::CFG_DATA_W-1:0] relax,
                                 input logic [lbd_pkg::CFG_DATA_W-1:0] move,
                                 input logic [lbd_pkg::CFG_DATA_W-1:0] cells);
        wait_drained();
        write_register(lbd_pkg::CFG_RELAX, relax);
        write_register(lbd_pkg::CFG_MOVE, move);
        write_register(lbd_pkg::CFG_CELLS, cells);
    endtask

    // Response checker: compare each beat with the oldest expectation
    initial
    begin : response_checker
        lattice_result_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("response beat with nothing outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.density_out !== want.density)
                        report_mismatch($sformatf(
                            "item %0d kind %0d cell %0d: density_out %0d, want %0d",
                            want.item_no, want.kind, want.cell_no,
                            rsp_ch.density_out, want.density));
                    if (rsp_ch.saturated !== want.saturated)
                        report_mismatch($sformatf(
                            "item %0d kind %0d cell %0d: saturated %b, want %b",
                            want.item_no, want.kind, want.cell_no,
                            rsp_ch.saturated, want.saturated));
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [lbd_pkg::IO_VALUE_W-1:0] pick_density();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? DENS_MAX : DENS_MIN;
            1, 2:    return lbd_pkg::IO_VALUE_W'($urandom);
            default: return lbd_pkg::IO_VALUE_W'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
        endcase
    endfunction

    function automatic logic [lbd_pkg::CFG_DATA_W-1:0] pick_relax();
        case ($urandom_range(0, 7))
            0:       return lbd_pkg::RELAX_MAX;
            1:       return '0;
            2:       return lbd_pkg::CFG_DATA_W'($urandom);
            default: return lbd_pkg::CFG_DATA_W'($urandom_range(0, 131072));
        endcase
    endfunction

    function automatic logic [lbd_pkg::CFG_DATA_W-1:0] pick_move();
        case ($urandom_range(0, 7))
            0:       return lbd_pkg::CFG_DATA_W'(lbd_pkg::ONE_Q16);
            1:       return '0;
            2:       return lbd_pkg::CFG_DATA_W'($urandom);
            default: return lbd_pkg::CFG_DATA_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Extreme densities under the reset settings, and reads of them
    task automatic test_load_extremes();
        send_item(lbd_pkg::KIND_LOAD, 7'd0, DENS_MAX);
        send_item(lbd_pkg::KIND_LOAD, 7'd1, DENS_MIN);
        send_item(lbd_pkg::KIND_LOAD, 7'd2, DENS_ZERO);
        send_item(lbd_pkg::KIND_LOAD, 7'd127, DENS_NEG1);
        send_item(lbd_pkg::KIND_LOAD, 7'd64, DENS_LSB);
        send_item(lbd_pkg::KIND_READ, 7'd0, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(KIND_SPARE, 7'd1, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(lbd_pkg::KIND_READ, 7'd127, lbd_pkg::IO_VALUE_W'($urandom));
    endtask

    // Load every remaining cell so no step or read touches an empty entry
    task automatic test_fill_ring();
        for (int i = 3; i < CELL_COUNT - 1; i++)
            if (i != 64)
                send_item(lbd_pkg::KIND_LOAD, lbd_pkg::INDEX_W'(i), pick_density());
    endtask

    // Steps with the reset ring length; the last cell sits outside the ring
    task automatic test_reset_settings_step();
        send_item(lbd_pkg::KIND_STEP, 7'd0, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(lbd_pkg::KIND_STEP, 7'd127, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(lbd_pkg::KIND_READ, 7'd99, lbd_pkg::IO_VALUE_W'($urandom));
    endtask

    // Register extremes, out-of-range values and the unused register index
    task automatic test_register_extremes();
        set_registers(18'd0, 18'd0, 18'd3);
        send_item(lbd_pkg::KIND_STEP, 7'd1, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(lbd_pkg::KIND_READ, 7'd2, lbd_pkg::IO_VALUE_W'($urandom));

        set_registers(lbd_pkg::RELAX_MAX, lbd_pkg::CFG_DATA_W'(lbd_pkg::ONE_Q16), 18'd128);
        send_item(lbd_pkg::KIND_STEP, 7'd127, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(lbd_pkg::KIND_READ, 7'd0, lbd_pkg::IO_VALUE_W'($urandom));

        // rate and fraction beyond their limits, ring length of zero
        set_registers(18'h3FFFF, 18'h3FFFF, 18'h3FF00);
        send_item(lbd_pkg::KIND_STEP, 7'd0, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(lbd_pkg::KIND_LOAD, 7'd5, DENS_MAX);

        set_registers(18'd200000, 18'd100000, 18'd255);
        send_item(lbd_pkg::KIND_STEP, 7'd64, lbd_pkg::IO_VALUE_W'($urandom));

        set_registers(18'd65536, 18'd32768, 18'd2);
        send_item(lbd_pkg::KIND_STEP, 7'd1, lbd_pkg::IO_VALUE_W'($urandom));

        // a write to the unused index must change nothing
        wait_drained();
        write_register(CFG_SPARE, 18'h3FFFF);
        send_item(lbd_pkg::KIND_STEP, 7'd0, lbd_pkg::IO_VALUE_W'($urandom));

        set_registers(18'd1, 18'd1, 18'd129);
        send_item(lbd_pkg::KIND_STEP, 7'd100, lbd_pkg::IO_VALUE_W'($urandom));
        send_item(KIND_SPARE, 7'd127, lbd_pkg::IO_VALUE_W'($urandom));
    endtask

    // Random phases: fresh registers each phase, mostly short rings
    task automatic test_random_traffic(input int unsigned item_total,
                                       input int unsigned phase_total);
        int unsigned per_phase;
        int unsigned ring_pick;
        int unsigned step_pct;
        int unsigned roll;
        per_phase = item_total / phase_total;
        for (int p = 0; p < phase_total; p++)
        begin
            ring_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 255)
                                                    : $urandom_range(0, 16);
            step_pct  = (ring_pick > 16) ? 5 : 15;
            set_registers(pick_relax(), pick_move(),
                          lbd_pkg::CFG_DATA_W'(($urandom_range(0, 1023) << 8) | ring_pick));
            for (int j = 0; j < per_phase; j++)
            begin
                // now and then hold off until the block has gone quiet
                if ($urandom_range(0, 99) < 2)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < step_pct)
                    send_item(lbd_pkg::KIND_STEP, lbd_pkg::INDEX_W'($urandom),
                              lbd_pkg::IO_VALUE_W'($urandom));
                else if (roll < step_pct + 30)
                    send_item(lbd_pkg::KIND_LOAD, lbd_pkg::INDEX_W'($urandom),
                              pick_density());
                else if (roll < 95)
                    send_item(lbd_pkg::KIND_READ, lbd_pkg::INDEX_W'($urandom),
                              lbd_pkg::IO_VALUE_W'($urandom));
                else
                    send_item(KIND_SPARE, lbd_pkg::INDEX_W'($urandom),
                              lbd_pkg::IO_VALUE_W'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        cmd_ch.valid      <= 1'b0;
        cmd_ch.kind       <= lbd_pkg::KIND_READ;
        cmd_ch.cell_index <= '0;
        cmd_ch.density_in <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.addr       <= lbd_pkg::CFG_RELAX;
        cfg_ch.data       <= '0;
        rst_n             <= 1'b0;

        relax_reg = lbd_pkg::RELAX_RESET;
        move_reg  = lbd_pkg::MOVE_RESET;
        cells_reg = lbd_pkg::CELLS_RESET;
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            rest_pop[i]    = '0;
            right_pop[i]   = '0;
            left_pop[i]    = '0;
            density_mem[i] = '0;
        end
        items_sent     = 0;
        mismatch_count = 0;
        send_idle_pct  = 8;
        recv_idle_pct  = 56;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_extremes();
        test_fill_ring();
        test_reset_settings_step();
        test_register_extremes();
        test_random_traffic(230, 6);

        send_idle_pct = 56;
        recv_idle_pct = 8;
        test_random_traffic(230, 6);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(230, 6);

        // Drain, then watch for stray beats
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("lattice_boltzmann_d1q3_diffusion test passed");
        else
            $display("lattice_boltzmann_d1q3_diffusion test failed");
        $finish;
    end

endmodule
